// ===== rtl/khcb_pkg.sv =====
// ----------------------------------------------------------------------------
// khcb_pkg
// Shared widths, codes and controller/datapath command types of the k-ary
// Huffman code builder.
// ----------------------------------------------------------------------------
package khcb_pkg;

	localparam int FUNC_W    = 2;
	localparam int SYM_W     = 8;
	localparam int WEIGHT_W  = 32;
	localparam int STATUS_W  = 2;
	localparam int DIGIT_W   = 4;
	localparam int LEN_W     = 7;
	localparam int BWAYS_W   = 5;
	localparam int NWEIGHT_W = 40;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [BWAYS_W-1:0] BWAYS_RESET = 5'd2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_LOAD  = 2'd1,
		FUNC_BUILD = 2'd2,
		FUNC_QUERY = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_BUILD_FAIL = 2'd1,
		ST_NO_CODE    = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_TAKE, OP_CLEAR, OP_LOAD, OP_RESP,
		OP_B_INIT, OP_B_CNT, OP_B_PAD, OP_SZ_INIT, OP_SZ_STEP,
		OP_F_INIT, OP_F_RUN, OP_F_PAD,
		OP_K_INIT, OP_S_INIT, OP_S_RUN, OP_S_TAKE, OP_M_NODE, OP_B_DONE,
		OP_Q_RD, OP_Q_CHK, OP_Q_NODE, OP_Q_STEP,
		OP_E_INIT, OP_E_RD, OP_E_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    issue;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic s_last;
		logic lt2;
		logic c_zero;
		logic roots_gt1;
		logic total_big;
		logic wi_lt_leaves;
		logic j_last;
		logic found;
		logic k_last;
		logic i_last;
		logic q_ok;
		logic wzero;
		logic at_root;
		logic hasp;
		logic len_full;
		logic len_zero;
		logic e_last;
	} dp_stat_t;

endpackage

// ===== rtl/khcb_item_if.sv =====
// ----------------------------------------------------------------------------
// khcb_item_if
// Request channel: function code, symbol and weight with valid/ready.
// ----------------------------------------------------------------------------
interface khcb_item_if import khcb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SYM_W-1:0]    symbol;
	logic [WEIGHT_W-1:0] weight;

	modport source(output valid, func, symbol, weight, input ready);
	modport sink(input valid, func, symbol, weight, output ready);
endinterface

// ===== rtl/khcb_result_if.sv =====
// ----------------------------------------------------------------------------
// khcb_result_if
// Result channel: status, symbol, code digit, code length and last flag.
// ----------------------------------------------------------------------------
interface khcb_result_if import khcb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SYM_W-1:0]    code_symbol;
	logic [DIGIT_W-1:0]  digit;
	logic [LEN_W-1:0]    code_length;
	logic                last;

	modport source(output valid, status, code_symbol, digit, code_length, last,
		input ready);
	modport sink(input valid, status, code_symbol, digit, code_length, last,
		output ready);
endinterface

// ===== rtl/khcb_ram.sv =====
// ----------------------------------------------------------------------------
// khcb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module khcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/khcb_dp.sv =====
// ----------------------------------------------------------------------------
// khcb_dp
// Datapath: symbol store, node store, code digit buffer, build and walk
// counters, min search compare and the result register.
// ----------------------------------------------------------------------------
module khcb_dp import khcb_pkg::*; #(
	parameter int ALPHABET   = 256,
	parameter int MAX_WAYS   = 16,
	parameter int NODE_SLOTS = 1024,
	parameter int MAX_CODE   = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [FUNC_W-1:0]   item_func,
	input  logic [SYM_W-1:0]    item_symbol,
	input  logic [WEIGHT_W-1:0] item_weight,
	input  logic [BWAYS_W-1:0]  bways,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [STATUS_W-1:0] out_status,
	output logic [SYM_W-1:0]    out_symbol,
	output logic [DIGIT_W-1:0]  out_digit,
	output logic [LEN_W-1:0]    out_length,
	output logic                out_last
);

	localparam int AW  = $clog2(ALPHABET);
	localparam int IW  = $clog2(NODE_SLOTS);
	localparam int CW  = $clog2(2 * (ALPHABET + MAX_WAYS) + NODE_SLOTS) + 1;
	localparam int KW  = $clog2(MAX_WAYS);
	localparam int DW  = $clog2(MAX_CODE);
	localparam int LW  = $clog2(MAX_CODE + 1);
	localparam int NDW = NWEIGHT_W + 1 + IW + DIGIT_W;

	func_t                func_q;
	logic [SYM_W-1:0]     sym_q;
	logic [WEIGHT_W-1:0]  wgt_q;
	logic [KW-1:0]        bm1_q;
	logic                 present_q [ALPHABET];
	logic                 built_q;
	logic [AW-1:0]        s_q;
	logic [CW-1:0]        leaves_q, total_q, roots_q, wi_q, j_q;
	logic [KW-1:0]        c_q, k_q;
	logic [NWEIGHT_W-1:0] sum_q, bw_q;
	logic [IW-1:0]        best_q, root_q, node_q;
	logic                 found_q;
	logic [LW-1:0]        len_q;
	logic [DW-1:0]        eidx_q;
	logic                 rv_s1, fv_s1, fpres_s1;
	logic [CW-1:0]        ridx_s1;
	logic [AW-1:0]        fs_s1;
	logic                 ov_q;

	logic [AW-1:0]        sym_a;
	logic                 sym_ok;
	logic [KW-1:0]        c_inc;
	logic [KW-1:0]        bm1_nxt;

	logic                 w_we, w_re;
	logic [AW-1:0]        w_raddr;
	logic [WEIGHT_W-1:0]  w_rd;
	logic [IW-1:0]        leaf_rd;
	logic                 n_we, n_re;
	logic [IW-1:0]        n_waddr, n_raddr;
	logic [NDW-1:0]       n_wdata, n_rd;
	logic [NWEIGHT_W-1:0] nd_w;
	logic                 nd_hp;
	logic [IW-1:0]        nd_par;
	logic [DIGIT_W-1:0]   nd_pos;
	logic                 d_we;
	logic [DIGIT_W-1:0]   d_rd;

	assign sym_a  = sym_q[AW-1:0];
	assign sym_ok = int'(sym_q) < ALPHABET;
	assign c_inc  = (c_q == bm1_q - KW'(1)) ? '0 : c_q + KW'(1);

	// clamp the base into 2..MAX_WAYS and keep base minus one
	always_comb begin
		if (bways < 5'd2) begin
			bm1_nxt = KW'(1);
		end else if (int'(bways) > MAX_WAYS) begin
			bm1_nxt = KW'(MAX_WAYS - 1);
		end else begin
			bm1_nxt = KW'(bways - 5'd1);
		end
	end

	assign {nd_w, nd_hp, nd_par, nd_pos} = n_rd;

	// symbol weights and leaf index per symbol
	assign w_we    = (cmd.op == OP_LOAD) && sym_ok;
	assign w_re    = ((cmd.op == OP_F_RUN) && cmd.issue) || (cmd.op == OP_Q_RD);
	assign w_raddr = (cmd.op == OP_Q_RD) ? sym_a : s_q;

	khcb_ram #(.WIDTH(WEIGHT_W), .DEPTH(ALPHABET)) u_wram (
		.clk(clk), .we(w_we), .waddr(sym_a), .wdata(wgt_q),
		.re(w_re), .raddr(w_raddr), .rdata(w_rd)
	);

	khcb_ram #(.WIDTH(IW), .DEPTH(ALPHABET)) u_leaf (
		.clk(clk), .we(fv_s1 && fpres_s1), .waddr(fs_s1), .wdata(wi_q[IW-1:0]),
		.re(cmd.op == OP_Q_RD), .raddr(sym_a), .rdata(leaf_rd)
	);

	// node store: weight, has-parent flag, parent index, child position
	always_comb begin
		n_we    = 1'b0;
		n_waddr = wi_q[IW-1:0];
		n_wdata = '0;
		if (fv_s1 && fpres_s1) begin
			n_we    = 1'b1;
			n_wdata = {NWEIGHT_W'(w_rd), 1'b0, {IW{1'b0}}, {DIGIT_W{1'b0}}};
		end else if (cmd.op == OP_F_PAD) begin
			n_we = 1'b1;
		end else if (cmd.op == OP_S_TAKE) begin
			n_we    = found_q;
			n_waddr = best_q;
			n_wdata = {bw_q, 1'b1, wi_q[IW-1:0], DIGIT_W'(k_q)};
		end else if (cmd.op == OP_M_NODE) begin
			n_we    = 1'b1;
			n_wdata = {sum_q, 1'b0, {IW{1'b0}}, {DIGIT_W{1'b0}}};
		end
	end

	assign n_re    = ((cmd.op == OP_S_RUN) && cmd.issue) || (cmd.op == OP_Q_NODE);
	assign n_raddr = (cmd.op == OP_Q_NODE) ? node_q : j_q[IW-1:0];

	khcb_ram #(.WIDTH(NDW), .DEPTH(NODE_SLOTS)) u_node (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_rd)
	);

	// digits of the walk, leaf side first
	assign d_we = (cmd.op == OP_Q_STEP) && nd_hp && !stat.len_full;

	khcb_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_CODE)) u_digit (
		.clk(clk), .we(d_we), .waddr(len_q[DW-1:0]), .wdata(nd_pos),
		.re(cmd.op == OP_E_RD), .raddr(eidx_q), .rdata(d_rd)
	);

	always_comb begin
		stat.out_free     = !ov_q || out_ready;
		stat.s_last       = s_q == AW'(ALPHABET - 1);
		stat.lt2          = leaves_q < CW'(2);
		stat.c_zero       = c_q == '0;
		stat.roots_gt1    = roots_q > CW'(1);
		stat.total_big    = int'(total_q) > NODE_SLOTS;
		stat.wi_lt_leaves = wi_q < leaves_q;
		stat.j_last       = j_q == wi_q - CW'(1);
		stat.found        = found_q;
		stat.k_last       = k_q == bm1_q;
		stat.i_last       = wi_q == total_q - CW'(1);
		stat.q_ok         = built_q && sym_ok && present_q[sym_a];
		stat.wzero        = w_rd == '0;
		stat.at_root      = node_q == root_q;
		stat.hasp         = nd_hp;
		stat.len_full     = int'(len_q) == MAX_CODE;
		stat.len_zero     = len_q == '0;
		stat.e_last       = eidx_q == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < ALPHABET; a++) begin
				present_q[a] <= 1'b0;
			end
			built_q <= 1'b0;
			rv_s1   <= 1'b0;
			fv_s1   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			rv_s1 <= (cmd.op == OP_S_RUN) && cmd.issue;
			fv_s1 <= (cmd.op == OP_F_RUN) && cmd.issue;
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_CLEAR: begin
					for (int a = 0; a < ALPHABET; a++) begin
						present_q[a] <= 1'b0;
					end
					built_q <= 1'b0;
				end
				OP_LOAD: begin
					if (sym_ok) begin
						present_q[sym_a] <= 1'b1;
						built_q          <= 1'b0;
					end
				end
				OP_B_INIT: built_q <= 1'b0;
				OP_B_DONE: built_q <= 1'b1;
				OP_RESP, OP_E_OUT: ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1  <= j_q;
		fpres_s1 <= present_q[s_q];
		fs_s1    <= s_q;
		// running minimum over parentless nodes, first index wins ties
		if (rv_s1 && !nd_hp && (!found_q || nd_w < bw_q)) begin
			best_q  <= ridx_s1[IW-1:0];
			bw_q    <= nd_w;
			found_q <= 1'b1;
		end
		if (fv_s1) begin
			wi_q <= wi_q + CW'(fpres_s1);
		end
		unique case (cmd.op)
			OP_TAKE: begin
				func_q <= func_t'(item_func);
				sym_q  <= item_symbol;
				wgt_q  <= item_weight;
				bm1_q  <= bm1_nxt;
			end
			OP_B_INIT: begin
				s_q      <= '0;
				leaves_q <= '0;
				c_q      <= '0;
			end
			OP_B_CNT: begin
				s_q <= s_q + AW'(1);
				if (present_q[s_q]) begin
					leaves_q <= leaves_q + CW'(1);
					c_q      <= (leaves_q == '0) ? '0 : c_inc;
				end
			end
			OP_B_PAD: begin
				leaves_q <= leaves_q + CW'(1);
				c_q      <= c_inc;
			end
			OP_SZ_INIT: begin
				roots_q <= leaves_q;
				total_q <= leaves_q;
			end
			OP_SZ_STEP: begin
				roots_q <= roots_q - CW'(bm1_q);
				total_q <= total_q + CW'(1);
			end
			OP_F_INIT: begin
				s_q  <= '0;
				wi_q <= '0;
			end
			OP_F_RUN: begin
				if (cmd.issue) begin
					s_q <= s_q + AW'(1);
				end
			end
			OP_F_PAD:  wi_q <= wi_q + CW'(1);
			OP_K_INIT: begin
				k_q   <= '0;
				sum_q <= '0;
			end
			OP_S_INIT: begin
				j_q     <= '0;
				found_q <= 1'b0;
			end
			OP_S_RUN: begin
				if (cmd.issue) begin
					j_q <= j_q + CW'(1);
				end
			end
			OP_S_TAKE: begin
				if (found_q) begin
					sum_q <= sum_q + bw_q;
					k_q   <= k_q + KW'(1);
				end
			end
			OP_M_NODE: wi_q <= wi_q + CW'(1);
			OP_B_DONE: root_q <= IW'(total_q - CW'(1));
			OP_Q_CHK: begin
				node_q <= leaf_rd;
				len_q  <= '0;
			end
			OP_Q_STEP: begin
				if (nd_hp && !stat.len_full) begin
					len_q  <= len_q + LW'(1);
					node_q <= nd_par;
				end
			end
			OP_E_INIT: eidx_q <= DW'(len_q - LW'(1));
			OP_E_OUT: begin
				eidx_q      <= eidx_q - DW'(1);
				out_status  <= ST_OK;
				out_symbol  <= sym_q;
				out_digit   <= d_rd;
				out_length  <= LEN_W'(len_q);
				out_last    <= stat.e_last;
			end
			OP_RESP: begin
				out_status <= cmd.code;
				out_symbol <= (func_q == FUNC_CLEAR || func_q == FUNC_BUILD) ? '0 : sym_q;
				out_digit  <= '0;
				out_length <= '0;
				out_last   <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;

endmodule

// ===== rtl/khcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// khcb_ctrl
// Controller: sequences clear, load, tree build and code query on the
// datapath, one request at a time.
// ----------------------------------------------------------------------------
module khcb_ctrl import khcb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [FUNC_W-1:0] item_func,
	output logic              item_ready,
	input  dp_stat_t          stat,
	output dp_cmd_t           cmd
);

	typedef enum logic [26:0] {
		S_IDLE   = 27'b1 << 0,
		S_CLEAR  = 27'b1 << 1,
		S_LOAD   = 27'b1 << 2,
		S_RESP   = 27'b1 << 3,
		S_BINIT  = 27'b1 << 4,
		S_BCNT   = 27'b1 << 5,
		S_BPAD   = 27'b1 << 6,
		S_SZINIT = 27'b1 << 7,
		S_SZ     = 27'b1 << 8,
		S_FINIT  = 27'b1 << 9,
		S_FILL   = 27'b1 << 10,
		S_FDRAIN = 27'b1 << 11,
		S_FPAD   = 27'b1 << 12,
		S_KINIT  = 27'b1 << 13,
		S_SINIT  = 27'b1 << 14,
		S_SRUN   = 27'b1 << 15,
		S_SDRAIN = 27'b1 << 16,
		S_TAKE   = 27'b1 << 17,
		S_MNODE  = 27'b1 << 18,
		S_BDONE  = 27'b1 << 19,
		S_QRD    = 27'b1 << 20,
		S_QCHK   = 27'b1 << 21,
		S_QNODE  = 27'b1 << 22,
		S_QSTEP  = 27'b1 << 23,
		S_EINIT  = 27'b1 << 24,
		S_ERD    = 27'b1 << 25,
		S_EOUT   = 27'b1 << 26
	} state_t;

	state_t  state_q, state_nxt;
	status_t code_q, code_nxt;

	assign item_ready = state_q == S_IDLE;

	always_comb begin
		state_nxt = state_q;
		code_nxt  = code_q;
		cmd.op    = OP_NONE;
		cmd.issue = 1'b0;
		cmd.code  = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.op = OP_TAKE;
					unique case (func_t'(item_func))
						FUNC_CLEAR: state_nxt = S_CLEAR;
						FUNC_LOAD:  state_nxt = S_LOAD;
						FUNC_BUILD: state_nxt = S_BINIT;
						FUNC_QUERY: state_nxt = S_QRD;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.op    = OP_CLEAR;
				code_nxt  = ST_OK;
				state_nxt = S_RESP;
			end
			S_LOAD: begin
				cmd.op    = OP_LOAD;
				code_nxt  = ST_OK;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.op    = OP_RESP;
					state_nxt = S_IDLE;
				end
			end
			S_BINIT: begin
				cmd.op    = OP_B_INIT;
				state_nxt = S_BCNT;
			end
			S_BCNT: begin
				cmd.op = OP_B_CNT;
				if (stat.s_last) begin
					state_nxt = S_BPAD;
				end
			end
			S_BPAD: begin
				priority if (stat.lt2) begin
					code_nxt  = ST_BUILD_FAIL;
					state_nxt = S_RESP;
				end else if (stat.c_zero) begin
					state_nxt = S_SZINIT;
				end else begin
					cmd.op = OP_B_PAD;
				end
			end
			S_SZINIT: begin
				cmd.op    = OP_SZ_INIT;
				state_nxt = S_SZ;
			end
			// one step per merge: total node count without a divider
			S_SZ: begin
				priority if (stat.roots_gt1) begin
					cmd.op = OP_SZ_STEP;
				end else if (stat.total_big) begin
					code_nxt  = ST_BUILD_FAIL;
					state_nxt = S_RESP;
				end else begin
					state_nxt = S_FINIT;
				end
			end
			S_FINIT: begin
				cmd.op    = OP_F_INIT;
				state_nxt = S_FILL;
			end
			S_FILL: begin
				cmd.op    = OP_F_RUN;
				cmd.issue = 1'b1;
				if (stat.s_last) begin
					state_nxt = S_FDRAIN;
				end
			end
			S_FDRAIN: begin
				cmd.op    = OP_F_RUN;
				state_nxt = S_FPAD;
			end
			S_FPAD: begin
				if (stat.wi_lt_leaves) begin
					cmd.op = OP_F_PAD;
				end else begin
					state_nxt = S_KINIT;
				end
			end
			S_KINIT: begin
				cmd.op    = OP_K_INIT;
				state_nxt = S_SINIT;
			end
			S_SINIT: begin
				cmd.op    = OP_S_INIT;
				state_nxt = S_SRUN;
			end
			S_SRUN: begin
				cmd.op    = OP_S_RUN;
				cmd.issue = 1'b1;
				if (stat.j_last) begin
					state_nxt = S_SDRAIN;
				end
			end
			S_SDRAIN: begin
				cmd.op    = OP_S_RUN;
				state_nxt = S_TAKE;
			end
			S_TAKE: begin
				cmd.op = OP_S_TAKE;
				if (!stat.found || stat.k_last) begin
					state_nxt = S_MNODE;
				end else begin
					state_nxt = S_SINIT;
				end
			end
			S_MNODE: begin
				cmd.op    = OP_M_NODE;
				state_nxt = stat.i_last ? S_BDONE : S_KINIT;
			end
			S_BDONE: begin
				cmd.op    = OP_B_DONE;
				code_nxt  = ST_OK;
				state_nxt = S_RESP;
			end
			S_QRD: begin
				cmd.op = OP_Q_RD;
				if (stat.q_ok) begin
					state_nxt = S_QCHK;
				end else begin
					code_nxt  = ST_NO_CODE;
					state_nxt = S_RESP;
				end
			end
			S_QCHK: begin
				cmd.op = OP_Q_CHK;
				if (stat.wzero) begin
					code_nxt  = ST_NO_CODE;
					state_nxt = S_RESP;
				end else begin
					state_nxt = S_QNODE;
				end
			end
			S_QNODE: begin
				priority if (!stat.at_root) begin
					cmd.op    = OP_Q_NODE;
					state_nxt = S_QSTEP;
				end else if (stat.len_zero) begin
					code_nxt  = ST_NO_CODE;
					state_nxt = S_RESP;
				end else begin
					state_nxt = S_EINIT;
				end
			end
			S_QSTEP: begin
				cmd.op = OP_Q_STEP;
				priority if (!stat.hasp) begin
					if (stat.len_zero) begin
						code_nxt  = ST_NO_CODE;
						state_nxt = S_RESP;
					end else begin
						state_nxt = S_EINIT;
					end
				end else if (stat.len_full) begin
					code_nxt  = ST_NO_CODE;
					state_nxt = S_RESP;
				end else begin
					state_nxt = S_QNODE;
				end
			end
			S_EINIT: begin
				cmd.op    = OP_E_INIT;
				state_nxt = S_ERD;
			end
			S_ERD: begin
				cmd.op    = OP_E_RD;
				state_nxt = S_EOUT;
			end
			S_EOUT: begin
				if (stat.out_free) begin
					cmd.op    = OP_E_OUT;
					state_nxt = stat.e_last ? S_IDLE : S_ERD;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_nxt;
			code_q  <= code_nxt;
		end
	end

endmodule

// ===== rtl/kary_huffman_code_builder.sv =====
// ----------------------------------------------------------------------------
// kary_huffman_code_builder
// Huffman code builder in base 2..16 with symbol store, tree build and
// per-symbol code query, one request at a time.
// ----------------------------------------------------------------------------
// clear and load update the store, then respond; build: a count pass and a fill pass
// over the symbol store, then, per merge, up to b node store scans at one node per cycle
// query: one node store read per code digit, then the digits go out leaf side last
// requests are taken one at a time; the next is accepted while a result waits
// reset clears the symbol store, drops the tree and sets branch_ways to 2
module kary_huffman_code_builder import khcb_pkg::*; #(
	parameter int ALPHABET   = 256,
	parameter int MAX_WAYS   = 16,
	parameter int NODE_SLOTS = 1024,
	parameter int MAX_CODE   = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	khcb_item_if.sink          item,
	khcb_result_if.source      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [BWAYS_W-1:0] bways_q;
	logic               reg_hit;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1] == 1'b0;
	assign prdata  = reg_hit ? PDATA_W'(bways_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bways_q <= BWAYS_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			bways_q <= pwdata[BWAYS_W-1:0];
		end
	end

	khcb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_func(item.func),
		.item_ready(item.ready),
		.stat(stat),
		.cmd(cmd)
	);

	khcb_dp #(
		.ALPHABET(ALPHABET),
		.MAX_WAYS(MAX_WAYS),
		.NODE_SLOTS(NODE_SLOTS),
		.MAX_CODE(MAX_CODE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.item_func(item.func),
		.item_symbol(item.symbol),
		.item_weight(item.weight),
		.bways(bways_q),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.out_status(result.status),
		.out_symbol(result.code_symbol),
		.out_digit(result.digit),
		.out_length(result.code_length),
		.out_last(result.last)
	);

endmodule

// ===== verif/kary_huffman_code_builder_tb.sv =====
// ----------------------------------------------------------------------------
// kary_huffman_code_builder_tb
// Self-checking bench for the k-ary Huffman code builder. Requests go in as
// clear, load, build and query. Each accepted request runs through an
// in-bench model of the symbol store and the tree. Code digits that come out
// are compared in order against that model. The code base is changed over
// APB between phases.
// ----------------------------------------------------------------------------
module kary_huffman_code_builder_tb;
	import khcb_pkg::*;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SYM_W-1:0]    sym;
		logic [DIGIT_W-1:0]  digit;
		logic [LEN_W-1:0]    len;
		logic                last;
	} code_digit_t;

	class code_scoreboard;
		bit [WEIGHT_W-1:0]     sym_w[256];
		bit                    sym_p[256];
		longint unsigned       node_w[1024];
		int                    node_par[1024];
		int                    node_pos[1024];
		bit                    node_hp[1024];
		int                    leaf_of[256];
		bit                    built;
		int                    node_cnt;
		bit [BWAYS_W-1:0]      ways;
		code_digit_t           digits_q[$];
		int                    errors;

		function new();
			foreach (sym_w[s]) begin
				sym_w[s] = 0;
				sym_p[s] = 0;
			end
			built = 0;
			node_cnt = 0;
			ways = BWAYS_RESET;
			errors = 0;
		endfunction

		function void push(status_t st, logic [SYM_W-1:0] s, int d, int l, bit lst);
			code_digit_t c;
			c.status = st;
			c.sym = s;
			c.digit = DIGIT_W'(d);
			c.len = LEN_W'(l);
			c.last = lst;
			digits_q.push_back(c);
		endfunction

		function status_t build_tree();
			int b, n, leaves, total, best;
			bit found;
			longint unsigned sum;
			b = ways;
			n = 0;
			if (b < 2) b = 2;
			if (b > 16) b = 16;
			built = 0;
			foreach (sym_p[s]) if (sym_p[s]) n++;
			if (n < 2) return ST_BUILD_FAIL;
			leaves = n + ((b - 1) - (n - 1) % (b - 1)) % (b - 1);
			total = leaves + (leaves - 1) / (b - 1);
			if (total > 1024) return ST_BUILD_FAIL;
			n = 0;
			for (int s = 0; s < 256; s++) begin
				if (sym_p[s]) begin
					node_w[n] = sym_w[s];
					node_hp[n] = 0;
					leaf_of[s] = n;
					n++;
				end
			end
			for (; n < leaves; n++) begin
				node_w[n] = 0;
				node_hp[n] = 0;
			end
			for (int i = leaves; i < total; i++) begin
				sum = 0;
				for (int k = 0; k < b; k++) begin
					best = 0;
					found = 0;
					for (int j = 0; j < i; j++) begin
						if (node_hp[j]) continue;
						if (!found || node_w[j] < node_w[best]) begin
							best = j;
							found = 1;
						end
					end
					if (!found) break;
					node_hp[best] = 1;
					node_par[best] = i;
					node_pos[best] = k;
					sum += node_w[best];
				end
				node_w[i] = sum;
				node_hp[i] = 0;
			end
			node_cnt = total;
			built = 1;
			return ST_OK;
		endfunction

		function void note_request(func_t f, logic [SYM_W-1:0] s, logic [WEIGHT_W-1:0] w);
			int digs[64];
			int len, node, steps;
			bit bad;
			case (f)
				FUNC_CLEAR: begin
					foreach (sym_w[i]) begin
						sym_w[i] = 0;
						sym_p[i] = 0;
					end
					built = 0;
					push(ST_OK, 0, 0, 0, 1);
				end
				FUNC_LOAD: begin
					sym_w[s] = w;
					sym_p[s] = 1;
					built = 0;
					push(ST_OK, s, 0, 0, 1);
				end
				FUNC_BUILD: push(build_tree(), 0, 0, 0, 1);
				default: begin
					if (!built || !sym_p[s] || sym_w[s] == 0) begin
						push(ST_NO_CODE, s, 0, 0, 1);
						return;
					end
					node = leaf_of[s];
					len = 0;
					steps = 0;
					bad = 0;
					while (node != node_cnt - 1 && steps < 1024) begin
						if (!node_hp[node]) break;
						if (len >= 64) begin
							bad = 1;
							break;
						end
						digs[len++] = node_pos[node];
						node = node_par[node];
						steps++;
					end
					if (bad || len == 0) push(ST_NO_CODE, s, 0, 0, 1);
					else for (int k = 0; k < len; k++)
						push(ST_OK, s, digs[len - 1 - k], len, k == len - 1);
				end
			endcase
		endfunction

		function void check_result(code_digit_t got);
			code_digit_t want;
			if (digits_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d sym %0d digit %0d len %0d last %0d",
						got.status, got.sym, got.digit, got.len, got.last);
				return;
			end
			want = digits_q.pop_front();
			if (got.status !== want.status || got.sym !== want.sym ||
				got.digit !== want.digit || got.len !== want.len ||
				got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp st %0d sym %0d dig %0d len %0d last %0d, got st %0d sym %0d dig %0d len %0d last %0d",
						want.status, want.sym, want.digit, want.len, want.last,
						got.status, got.sym, got.digit, got.len, got.last);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	khcb_item_if   item_ch();
	khcb_result_if result_ch();

	kary_huffman_code_builder dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	code_scoreboard sb = new();
	int send_idle_pct, recv_stall_pct;
	int sent;
	int quiet_cycles;
	logic [SYM_W-1:0] loaded_syms[$];

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		code_digit_t got;
		if (result_ch.valid && result_ch.ready) begin
			got.status = result_ch.status;
			got.sym = result_ch.code_symbol;
			got.digit = result_ch.digit;
			got.len = result_ch.code_length;
			got.last = result_ch.last;
			sb.check_result(got);
		end
	end

	// watchdog: cycles with no request or result moving
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 200000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send(func_t f, logic [SYM_W-1:0] s, logic [WEIGHT_W-1:0] w);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.symbol <= s;
		item_ch.weight <= w;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_request(f, s, w);
		sent++;
		if (sent < 130) begin
			send_idle_pct = 29;
			recv_stall_pct = 80;
		end else if (sent < 260) begin
			send_idle_pct = 80;
			recv_stall_pct = 29;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.digits_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_ways(logic [BWAYS_W-1:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.ways = v;
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(9))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2, 3: return $urandom;
			default: return $urandom_range(1, 50);
		endcase
	endfunction

	task automatic load_sym(logic [SYM_W-1:0] s, logic [WEIGHT_W-1:0] w);
		send(FUNC_LOAD, s, w);
		loaded_syms.push_back(s);
	endtask

	initial begin
		logic [BWAYS_W-1:0] ways_list[8] = '{5'd16, 5'd0, 5'd3, 5'd17, 5'd31, 5'd1, 5'd5, 5'd2};
		int kind, n, ph;
		logic [WEIGHT_W-1:0] fa, fb, fc;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_CLEAR;
		item_ch.symbol = '0;
		item_ch.weight = '0;
		result_ch.ready = 1'b0;
		quiet_cycles = 0;
		sent = 0;
		send_idle_pct = 29;
		recv_stall_pct = 80;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: failing builds, zero and full weights, dropped tree
		send(FUNC_QUERY, 8'd7, 0);
		send(FUNC_BUILD, 8'hFF, 32'hFFFF_FFFF);
		send(FUNC_LOAD, 8'd0, 0);
		send(FUNC_BUILD, 0, 0);
		send(FUNC_LOAD, 8'hFF, 32'hFFFF_FFFF);
		send(FUNC_LOAD, 8'hAA, 1);
		send(FUNC_LOAD, 8'h55, 32'hFFFF_FFFF);
		send(FUNC_BUILD, 0, 0);
		send(FUNC_QUERY, 8'd0, 0);
		send(FUNC_QUERY, 8'hFF, 0);
		send(FUNC_QUERY, 8'hAA, 32'hFFFF_FFFF);
		send(FUNC_QUERY, 8'h55, 0);
		send(FUNC_QUERY, 8'h12, 0);
		send(FUNC_LOAD, 8'h12, 3);
		send(FUNC_QUERY, 8'hFF, 0);
		send(FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF);
		send(FUNC_BUILD, 0, 0);
		send(FUNC_QUERY, 8'hAA, 0);

		ph = 0;
		while (sent < 360) begin
			if (ph % 2 == 0)
				set_ways(ph < 16 ? ways_list[(ph / 2) % 8] : BWAYS_W'($urandom_range(0, 31)));
			ph++;
			loaded_syms.delete();
			send(FUNC_CLEAR, SYM_W'($urandom), $urandom);
			kind = $urandom_range(11);
			if (kind == 0) begin
				// fibonacci weights make a deep code
				fa = 1;
				fb = 1;
				for (int i = 0; i < 24; i++) begin
					load_sym(SYM_W'(10 + i), fa);
					fc = fa + fb;
					fa = fb;
					fb = fc;
				end
			end else begin
				n = (kind == 1) ? 40 : $urandom_range(0, 12);
				for (int i = 0; i < n; i++) load_sym(SYM_W'($urandom), pick_weight());
			end
			if ($urandom_range(9) == 0)
				send(func_t'($urandom_range(3)), SYM_W'($urandom), $urandom);
			send(FUNC_BUILD, SYM_W'($urandom), $urandom);
			foreach (loaded_syms[i]) send(FUNC_QUERY, loaded_syms[i], $urandom);
			send(FUNC_QUERY, SYM_W'($urandom), $urandom);
			if ($urandom_range(4) == 0) begin
				send(FUNC_LOAD, SYM_W'($urandom), pick_weight());
				if (loaded_syms.size() != 0) send(FUNC_QUERY, loaded_syms[0], 0);
			end
		end
		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.digits_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
